@@ hdl/drt_pkg.sv @@
// Package for the delayed ramp timer: widths, phase and sequencer codes,
// and the structs passed between the top level and the timing core.
// Used by drt_core.sv and delayed_ramp_timer.sv; depends on nothing.
`default_nettype none

package drt_pkg;

    localparam int TIME_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = FRAC_BITS + 1;
    localparam int SUB_W     = ((TIME_BITS > POS_W) ? TIME_BITS : POS_W) + 1;
    localparam int CNT_W     = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;
    localparam int IN_W      = ((TIME_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_W     = ((POS_W + 2 + 1 + 7) / 8) * 8;
    localparam int ADDR_W    = 2;

    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << FRAC_BITS;

    localparam logic [ADDR_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [ADDR_W-1:0] REG_DURATION = 2'd1;
    localparam logic [ADDR_W-1:0] REG_LOOPING  = 2'd2;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_PLAY = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_DELAY = 2'd1,
        PH_TRANS = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ELAPSED,
        ST_CHECK,
        ST_WRAP,
        ST_RESTART,
        ST_DIVPREP,
        ST_DIV,
        ST_FINISH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] delay_ms;
        logic [TIME_BITS-1:0] duration_ms;
        logic                 looping;
    } cfg_t;

    typedef struct packed {
        logic                 cmd;
        logic [TIME_BITS-1:0] now_ms;
        logic                 reverse;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [1:0]       phase;
        logic             updated;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/drt_core.sv @@
// Timing core of the delayed ramp timer: phase state, a small sequencer and
// one shared subtractor for elapsed time, compares and restoring division.
// Depends on drt_pkg.
`default_nettype none

module drt_core import drt_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire cfg_t    cfg,
    input  wire logic    in_start,
    input  wire item_t   in_item,
    input  wire logic    out_free,
    output logic         core_idle,
    output logic         out_done,
    output result_t      out_result
);

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic                 rev_reg, rev_next;
    logic [POS_W-1:0]     ramp_reg, ramp_next;
    logic                 upd_reg, upd_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [POS_W-1:0]     quot_reg, quot_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic [SUB_W-1:0]     sub_a, sub_b;
    logic [SUB_W:0]       sub_res;
    logic                 borrow;

    assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow  = sub_res[SUB_W];

    always_comb begin
        sub_a = SUB_W'(elapsed_reg);
        sub_b = SUB_W'(cfg.duration_ms);
        case (state_reg)
            ST_ELAPSED: begin
                sub_a = SUB_W'(now_reg);
                sub_b = SUB_W'(start_reg);
            end
            ST_CHECK: begin
                if (phase_reg == PH_DELAY) begin
                    sub_a = SUB_W'(elapsed_reg);
                    sub_b = SUB_W'(cfg.delay_ms);
                end else begin
                    sub_a = SUB_W'(cfg.duration_ms);
                    sub_b = SUB_W'(elapsed_reg);
                end
            end
            ST_RESTART: begin
                sub_a = SUB_W'(now_reg);
                sub_b = SUB_W'(elapsed_reg);
            end
            ST_DIV: begin
                sub_a = SUB_W'({rem_reg, 1'b0});
                sub_b = SUB_W'(cfg.duration_ms);
            end
            ST_FINISH: begin
                sub_a = SUB_W'(POS_ONE);
                sub_b = SUB_W'(quot_reg);
            end
            default: begin
                sub_a = SUB_W'(elapsed_reg);
                sub_b = SUB_W'(cfg.duration_ms);
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_start) begin
                    if (in_item.cmd == CMD_TICK && phase_reg != PH_IDLE) begin
                        state_next = ST_ELAPSED;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ELAPSED: state_next = ST_CHECK;
            ST_CHECK: begin
                if (phase_reg == PH_DELAY) begin
                    state_next = ST_DONE;
                end else if (borrow && cfg.looping) begin
                    state_next = ST_WRAP;
                end else begin
                    state_next = ST_DIVPREP;
                end
            end
            ST_WRAP:    state_next = ST_RESTART;
            ST_RESTART: state_next = ST_DIVPREP;
            ST_DIVPREP: begin
                if (cfg.duration_ms == '0 || !borrow) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (count_reg == CNT_W'(FRAC_BITS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        phase_next   = phase_reg;
        start_next   = start_reg;
        rev_next     = rev_reg;
        ramp_next    = ramp_reg;
        upd_next     = upd_reg;
        now_next     = now_reg;
        elapsed_next = elapsed_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        count_next   = count_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_start) begin
                    now_next = in_item.now_ms;
                    upd_next = 1'b0;
                    if (in_item.cmd == CMD_PLAY) begin
                        rev_next   = in_item.reverse;
                        phase_next = PH_DELAY;
                        ramp_next  = '0;
                        start_next = in_item.now_ms;
                    end
                end
            end
            ST_ELAPSED: elapsed_next = sub_res[TIME_BITS-1:0];
            ST_CHECK: begin
                if (phase_reg == PH_DELAY) begin
                    if (!borrow) begin
                        phase_next = PH_TRANS;
                        start_next = now_reg;
                    end
                end else if (borrow && !cfg.looping) begin
                    elapsed_next = cfg.duration_ms;
                    phase_next   = PH_IDLE;
                end
            end
            ST_WRAP:    elapsed_next = sub_res[TIME_BITS-1:0];
            ST_RESTART: start_next   = sub_res[TIME_BITS-1:0];
            ST_DIVPREP: begin
                quot_next  = POS_ONE;
                rem_next   = elapsed_reg;
                count_next = '0;
                if (cfg.duration_ms != '0 && borrow) begin
                    quot_next = '0;
                end
            end
            ST_DIV: begin
                quot_next  = {quot_reg[POS_W-2:0], !borrow};
                count_next = count_reg + CNT_W'(1);
                if (!borrow) begin
                    rem_next = sub_res[TIME_BITS-1:0];
                end else begin
                    rem_next = sub_a[TIME_BITS-1:0];
                end
            end
            ST_FINISH: begin
                upd_next  = 1'b1;
                ramp_next = rev_reg ? sub_res[POS_W-1:0] : quot_reg;
            end
            default: begin
                upd_next = upd_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IDLE;
            start_reg <= '0;
            rev_reg   <= 1'b0;
            ramp_reg  <= '0;
            upd_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            start_reg <= start_next;
            rev_reg   <= rev_next;
            ramp_reg  <= ramp_next;
            upd_reg   <= upd_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg     <= now_next;
        elapsed_reg <= elapsed_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        count_reg   <= count_next;
    end

    assign core_idle           = (state_reg == ST_IDLE);
    assign out_done            = (state_reg == ST_DONE) && out_free;
    assign out_result.position = ramp_reg;
    assign out_result.phase    = phase_reg;
    assign out_result.updated  = upd_reg;

    a_start_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_start |-> state_reg == ST_IDLE)
        else $error("item started while the sequencer was busy");

    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV |-> rem_reg < cfg.duration_ms)
        else $error("division remainder not below the duration");

    a_ramp_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        ramp_reg <= POS_ONE)
        else $error("ramp position above one");

    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVPREP && state_next == ST_DIV) |=> count_reg == '0)
        else $error("division did not start at step zero");

    a_updated_in_trans: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH |-> phase_reg != PH_DELAY)
        else $error("position recomputed during the delay phase");

endmodule

`default_nettype wire

@@ hdl/delayed_ramp_timer.sv @@
// Delayed ramp timer: a play transfer arms the delay, ticks advance the ramp.
// Play transfers and idle ticks go straight to the result; delay-phase ticks add the
// elapsed and compare steps; transition ticks also run the 16-step division of the shared
// subtractor (skipped when the position saturates); a looping wrap adds wrap and restart.
// One item in flight; s_tready returns with m_tvalid, so an output stall holds off the next item.
// Reset (aresetn low, synchronous) clears the state, phase, start-time, ramp, config and valid registers.
`default_nettype none

module delayed_ramp_timer import drt_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [ADDR_W-1:0]    cfg_addr,
    input  wire logic [TIME_BITS-1:0] cfg_wdata,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_W-1:0]      s_tdata,   // now_ms, reverse
    input  wire logic                 s_tuser,   // cmd
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [OUT_W-1:0]          m_tdata    // position, phase, updated
);

    cfg_t             cfg_reg, cfg_next;
    logic             m_tvalid_reg, m_tvalid_next;
    result_t          res_reg, res_next;
    item_t            item;
    result_t          core_result;
    logic             core_idle;
    logic             core_done;
    logic             out_free;
    logic             in_start;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_DELAY:    cfg_next.delay_ms    = cfg_wdata;
                REG_DURATION: cfg_next.duration_ms = cfg_wdata;
                REG_LOOPING:  cfg_next.looping     = cfg_wdata[0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    assign item.cmd     = s_tuser;
    assign item.now_ms  = s_tdata[TIME_BITS-1:0];
    assign item.reverse = s_tdata[TIME_BITS];

    assign s_tready = core_idle;
    assign in_start = s_tvalid && core_idle;
    assign out_free = !m_tvalid_reg || m_tready;

    drt_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_start   (in_start),
        .in_item    (item),
        .out_free   (out_free),
        .core_idle  (core_idle),
        .out_done   (core_done),
        .out_result (core_result)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        res_next      = res_reg;
        if (core_done) begin
            m_tvalid_next = 1'b1;
            res_next      = core_result;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cfg_reg      <= cfg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({res_reg.updated, res_reg.phase, res_reg.position});

endmodule

`default_nettype wire
